FILE: hdl/matrix3x3_inverse_top_assert.svh
// Assertion macros for the 3x3 matrix inverse block.
// Used by the port checker; no other dependencies.
`ifndef MATRIX3X3_INVERSE_TOP_ASSERT_SVH
`define MATRIX3X3_INVERSE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define M3INV_AST_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("m3inv check failed");

// Next-cycle implication, disabled during reset
`define M3INV_AST_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("m3inv check failed");

`endif

FILE: hdl/m3inv_pkg.sv
// Shared types and constants for the 3x3 matrix inverse block.
// No dependencies.
package m3inv_pkg;

   localparam int ElemW   = 32;   // Q16.16 element
   localparam int NumElem = 9;
   localparam int ProdW   = 64;   // element product, Q32.32
   localparam int MinW    = 65;   // minor, Q32.32
   localparam int DetW    = 99;   // determinant, Q48.48
   localparam int QW      = 33;   // quotient bits kept after the range check
   localparam int ShiftW  = 32;
   localparam int SingDet = 66;   // 0.001 in Q16.16
   localparam int QDepth  = 2;
   localparam int QPtrW   = 1;

   localparam logic [DetW-1:0]  SingDetQ = DetW'(SingDet) << ShiftW;
   localparam logic [QW-1:0]    QNegLim  = 33'h080000000;
   localparam logic [QW-1:0]    QPosLim  = 33'h07FFFFFFF;
   localparam logic [ElemW-1:0] ResMax   = 32'h7FFFFFFF;
   localparam logic [ElemW-1:0] ResMin   = 32'h80000000;

   // Cofactor magnitude plus the sign of the final quotient
   typedef struct packed {
      logic            neg;
      logic [MinW-1:0] mag;
   } cof_type;

   // One classified matrix handed from front to back
   typedef struct packed {
      cof_type [NumElem-1:0] cof;
      logic [DetW-1:0]       dmag;
      logic                  singular;
   } entry_type;

endpackage

FILE: hdl/m3inv_front.sv
// Front end: accepts a matrix, forms minors and the determinant, classifies.
// Depends on m3inv_pkg.
module m3inv_front (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         in_valid,
   output logic                                         in_ready,
   input  logic [m3inv_pkg::NumElem-1:0][m3inv_pkg::ElemW-1:0] elem,
   output logic                                         push_valid,
   input  logic                                         push_ready,
   output m3inv_pkg::entry_type                         push_data
);

   localparam int NE = m3inv_pkg::NumElem;
   localparam int PW = m3inv_pkg::ProdW;
   localparam int MW = m3inv_pkg::MinW;
   localparam int DW = m3inv_pkg::DetW;
   localparam int EW = m3inv_pkg::ElemW;
   localparam int ShiftLo = m3inv_pkg::ShiftW;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en_f;

   logic signed [PW-1:0] p_in [NE];
   logic signed [PW-1:0] s_in [NE];
   logic signed [PW-1:0] p_ff [NE];
   logic signed [PW-1:0] s_ff [NE];
   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];
   logic signed [MW-1:0] m2_ff [NE];
   logic signed [MW-1:0] m3_ff [NE];
   logic signed [MW-1:0] m4_ff [NE];
   logic signed [MW-1:0] m5_ff [NE];
   logic signed [MW-1:0] lo_in [3];
   logic signed [MW-1:0] hi_in [3];
   logic signed [MW-1:0] lo_ff [3];
   logic signed [MW-1:0] hi_ff [3];
   logic signed [DW-1:0] t_in [3];
   logic signed [DW-1:0] t_ff [3];
   logic signed [DW-1:0] det_in;
   logic signed [DW-1:0] det_ff;

   logic          det_zero;
   logic [DW-1:0] det_use;
   logic          det_neg;

   // Stall the whole front only when its last stage cannot hand off
   assign en_f       = !v5_ff || push_ready;
   assign in_ready   = en_f;
   assign push_valid = v5_ff;

   // Two element products per minor
   for (genvar gi = 0; gi < NE; gi++) begin : g_prod
      localparam int R  = gi / 3;
      localparam int C  = gi % 3;
      localparam int RA = (R == 0) ? 1 : 0;
      localparam int RB = (R == 2) ? 1 : 2;
      localparam int CA = (C == 0) ? 1 : 0;
      localparam int CB = (C == 2) ? 1 : 2;
      assign p_in[gi] = $signed(elem[RA*3+CA]) * $signed(elem[RB*3+CB]);
      assign s_in[gi] = $signed(elem[RA*3+CB]) * $signed(elem[RB*3+CA]);
   end

   // Split each row-0 minor into its low 32 bits and its upper bits for the determinant products
   for (genvar k = 0; k < 3; k++) begin : g_det
      assign lo_in[k] = $signed({1'b0, m2_ff[k][ShiftLo-1:0]}) * e2_ff[k];
      assign hi_in[k] = $signed(m2_ff[k][MW-1:ShiftLo]) * e2_ff[k];
      assign t_in[k]  = {{(DW-MW-ShiftLo){hi_ff[k][MW-1]}}, hi_ff[k], {ShiftLo{1'b0}}}
                      + {{(DW-MW){lo_ff[k][MW-1]}}, lo_ff[k]};
   end

   assign det_in = t_ff[0] - t_ff[1] + t_ff[2];

   // Classify: replace a zero determinant, take magnitudes and result signs
   always_comb begin
      det_zero = (det_ff == '0);
      det_use  = det_zero ? m3inv_pkg::SingDetQ : det_ff;
      det_neg  = det_use[DW-1];
      push_data.dmag     = det_neg ? (~det_use + DW'(1)) : det_use;
      push_data.singular = det_zero;
   end

   // Output (r,c) takes the cofactor of (c,r)
   for (genvar go = 0; go < NE; go++) begin : g_cof
      localparam int R = go / 3;
      localparam int C = go % 3;
      logic signed [MW-1:0] cof;
      always_comb begin
         cof = (((R + C) % 2) != 0) ? -m5_ff[C*3+R] : m5_ff[C*3+R];
         push_data.cof[go].mag = cof[MW-1] ? -cof : cof;
         push_data.cof[go].neg = cof[MW-1] ^ det_neg;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en_f) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en_f) begin
         for (int i = 0; i < NE; i++) begin
            p_ff[i]  <= p_in[i];
            s_ff[i]  <= s_in[i];
            m2_ff[i] <= {p_ff[i][PW-1], p_ff[i]} - {s_ff[i][PW-1], s_ff[i]};
            m3_ff[i] <= m2_ff[i];
            m4_ff[i] <= m3_ff[i];
            m5_ff[i] <= m4_ff[i];
         end
         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= $signed(elem[k]);
            e2_ff[k] <= e1_ff[k];
            lo_ff[k] <= lo_in[k];
            hi_ff[k] <= hi_in[k];
            t_ff[k]  <= t_in[k];
         end
         det_ff <= det_in;
      end
   end

endmodule

FILE: hdl/m3inv_queue.sv
// Two-entry queue between the front and back parts.
// Depends on m3inv_pkg.
module m3inv_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  m3inv_pkg::entry_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output m3inv_pkg::entry_type pop_data
);

   localparam int PW = m3inv_pkg::QPtrW;

   m3inv_pkg::entry_type mem_ff [m3inv_pkg::QDepth];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign push_ready = (cnt_ff != (PW+1)'(m3inv_pkg::QDepth));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   // Track pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: hdl/m3inv_back.sv
// Back end: nine pipelined restoring dividers, saturation and output register.
// Depends on m3inv_pkg.
module m3inv_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  m3inv_pkg::entry_type pop_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [m3inv_pkg::NumElem-1:0][m3inv_pkg::ElemW-1:0] res,
   output logic                 singular,
   output logic                 saturated
);

   localparam int NE = m3inv_pkg::NumElem;
   localparam int DW = m3inv_pkg::DetW;
   localparam int MW = m3inv_pkg::MinW;
   localparam int QW = m3inv_pkg::QW;
   localparam int EW = m3inv_pkg::ElemW;

   logic en_b;
   logic v_ff [0:QW];
   logic [DW-1:0] dmag_ff [0:QW];
   logic sing_ff [0:QW];
   logic out_valid_ff;
   logic [NE-1:0][EW-1:0] res_ff;
   logic [NE-1:0][EW-1:0] res_in;
   logic [NE-1:0] sat_in;
   logic sing_out_ff, sat_out_ff;

   assign en_b      = !out_valid_ff || out_ready;
   assign pop_ready = en_b;
   assign out_valid = out_valid_ff;
   assign res       = res_ff;
   assign singular  = sing_out_ff;
   assign saturated = sat_out_ff;

   // Advance valid bits through the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QW; j++) v_ff[j] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en_b) begin
         v_ff[0] <= pop_valid;
         for (int j = 1; j <= QW; j++) v_ff[j] <= v_ff[j-1];
         out_valid_ff <= v_ff[QW];
      end
   end

   // Carry divisor and flag alongside
   always_ff @(posedge clock) begin
      if (en_b) begin
         dmag_ff[0] <= pop_data.dmag;
         sing_ff[0] <= pop_data.singular;
         for (int j = 1; j <= QW; j++) begin
            dmag_ff[j] <= dmag_ff[j-1];
            sing_ff[j] <= sing_ff[j-1];
         end
      end
   end

   for (genvar li = 0; li < NE; li++) begin : g_lane
      logic [DW-1:0] rem_ff [0:QW];
      logic [QW-1:0] q_ff [0:QW];
      logic          neg_ff [0:QW];
      logic          ovf_ff [0:QW];
      logic          nb_ff;
      logic [MW-1:0] amag;
      logic          ovf_in;

      // Quotient needs more than QW bits when the magnitude reaches twice the divisor
      assign amag   = pop_data.cof[li].mag;
      assign ovf_in = {{(DW+1-MW){1'b0}}, amag} >= {pop_data.dmag, 1'b0};

      always_ff @(posedge clock) begin
         if (en_b) begin
            rem_ff[0] <= DW'(amag >> 1);
            q_ff[0]   <= '0;
            neg_ff[0] <= pop_data.cof[li].neg;
            ovf_ff[0] <= ovf_in;
            nb_ff     <= amag[0];
         end
      end

      // One quotient bit per stage
      for (genvar j = 1; j <= QW; j++) begin : g_step
         logic [DW:0]   t;
         logic          ge;
         logic [DW-1:0] rem_in;
         always_comb begin
            t      = {rem_ff[j-1], (j == 1) ? nb_ff : 1'b0};
            ge     = t >= {1'b0, dmag_ff[j-1]};
            rem_in = ge ? DW'(t - {1'b0, dmag_ff[j-1]}) : DW'(t);
         end
         always_ff @(posedge clock) begin
            if (en_b) begin
               rem_ff[j] <= rem_in;
               q_ff[j]   <= {q_ff[j-1][QW-2:0], ge};
               neg_ff[j] <= neg_ff[j-1];
               ovf_ff[j] <= ovf_ff[j-1];
            end
         end
      end

      // Apply sign and clip to the Q16.16 range
      always_comb begin
         if (neg_ff[QW]) begin
            sat_in[li] = ovf_ff[QW] || (q_ff[QW] > m3inv_pkg::QNegLim);
            res_in[li] = sat_in[li] ? m3inv_pkg::ResMin : (~q_ff[QW][EW-1:0] + EW'(1));
         end else begin
            sat_in[li] = ovf_ff[QW] || (q_ff[QW] > m3inv_pkg::QPosLim);
            res_in[li] = sat_in[li] ? m3inv_pkg::ResMax : q_ff[QW][EW-1:0];
         end
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (en_b) begin
         res_ff      <= res_in;
         sing_out_ff <= sing_ff[QW];
         sat_out_ff  <= |sat_in;
      end
   end

endmodule

FILE: hdl/matrix3x3_inverse_top.sv
// Top level of the 3x3 matrix inverse block (adjugate over determinant).
// Depends on m3inv_pkg, m3inv_front, m3inv_queue, m3inv_back.
//
// Usage:
//   Request channel req_*: nine signed Q16.16 elements, taken when
//   req_valid and req_ready are both high at a rising clock edge.
//   Response channel rsp_*: nine signed Q16.16 inverse elements plus
//   rsp_singular (zero determinant replaced by 0.001) and rsp_saturated
//   (some element clipped), delivered under rsp_valid/rsp_ready.
//   Throughput: one request per cycle while responses are taken.
//   Pipeline: 5 front stages (products, minors, determinant), one queue
//   slot, 35 back stages (33 restoring divider steps, one per quotient
//   bit, plus load and output stages).
//   A two-entry queue separates the front from the divider pipeline, so
//   the front keeps taking requests until the queue fills after a
//   response stall; the divider pipeline and output register hold while
//   rsp_valid is high and rsp_ready is low.
//   Reset (synchronous, active high) drops all requests in flight;
//   req_ready is high in the first cycle after reset.
module matrix3x3_inverse_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_r0c0,
   input  logic [31:0] req_r0c1,
   input  logic [31:0] req_r0c2,
   input  logic [31:0] req_r1c0,
   input  logic [31:0] req_r1c1,
   input  logic [31:0] req_r1c2,
   input  logic [31:0] req_r2c0,
   input  logic [31:0] req_r2c1,
   input  logic [31:0] req_r2c2,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_r0c0,
   output logic [31:0] rsp_r0c1,
   output logic [31:0] rsp_r0c2,
   output logic [31:0] rsp_r1c0,
   output logic [31:0] rsp_r1c1,
   output logic [31:0] rsp_r1c2,
   output logic [31:0] rsp_r2c0,
   output logic [31:0] rsp_r2c1,
   output logic [31:0] rsp_r2c2,
   output logic        rsp_singular,
   output logic        rsp_saturated
);

   logic [m3inv_pkg::NumElem-1:0][m3inv_pkg::ElemW-1:0] elem;
   logic [m3inv_pkg::NumElem-1:0][m3inv_pkg::ElemW-1:0] res;
   m3inv_pkg::entry_type push_data, pop_data;
   logic push_valid, push_ready, pop_valid, pop_ready;

   assign elem[0] = req_r0c0;
   assign elem[1] = req_r0c1;
   assign elem[2] = req_r0c2;
   assign elem[3] = req_r1c0;
   assign elem[4] = req_r1c1;
   assign elem[5] = req_r1c2;
   assign elem[6] = req_r2c0;
   assign elem[7] = req_r2c1;
   assign elem[8] = req_r2c2;

   m3inv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .elem       (elem),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   m3inv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   m3inv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .res       (res),
      .singular  (rsp_singular),
      .saturated (rsp_saturated)
   );

   assign rsp_r0c0 = res[0];
   assign rsp_r0c1 = res[1];
   assign rsp_r0c2 = res[2];
   assign rsp_r1c0 = res[3];
   assign rsp_r1c1 = res[4];
   assign rsp_r1c2 = res[5];
   assign rsp_r2c0 = res[6];
   assign rsp_r2c1 = res[7];
   assign rsp_r2c2 = res[8];

endmodule

FILE: hdl/m3inv_checker.sv
// Port-level checks for the 3x3 matrix inverse block, bound to the top level.
// Depends on matrix3x3_inverse_top_assert.svh.
`include "matrix3x3_inverse_top_assert.svh"

module m3inv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [31:0] req_r0c0,
   input logic [31:0] req_r0c1,
   input logic [31:0] req_r0c2,
   input logic [31:0] req_r1c0,
   input logic [31:0] req_r1c1,
   input logic [31:0] req_r1c2,
   input logic [31:0] req_r2c0,
   input logic [31:0] req_r2c1,
   input logic [31:0] req_r2c2,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_r0c0,
   input logic [31:0] rsp_r0c1,
   input logic [31:0] rsp_r0c2,
   input logic [31:0] rsp_r1c0,
   input logic [31:0] rsp_r1c1,
   input logic [31:0] rsp_r1c2,
   input logic [31:0] rsp_r2c0,
   input logic [31:0] rsp_r2c1,
   input logic [31:0] rsp_r2c2,
   input logic        rsp_singular,
   input logic        rsp_saturated
);

   logic any_clip;

   // Some element sits at a Q16.16 limit
   assign any_clip =
      (rsp_r0c0 == 32'h7FFFFFFF) || (rsp_r0c0 == 32'h80000000) ||
      (rsp_r0c1 == 32'h7FFFFFFF) || (rsp_r0c1 == 32'h80000000) ||
      (rsp_r0c2 == 32'h7FFFFFFF) || (rsp_r0c2 == 32'h80000000) ||
      (rsp_r1c0 == 32'h7FFFFFFF) || (rsp_r1c0 == 32'h80000000) ||
      (rsp_r1c1 == 32'h7FFFFFFF) || (rsp_r1c1 == 32'h80000000) ||
      (rsp_r1c2 == 32'h7FFFFFFF) || (rsp_r1c2 == 32'h80000000) ||
      (rsp_r2c0 == 32'h7FFFFFFF) || (rsp_r2c0 == 32'h80000000) ||
      (rsp_r2c1 == 32'h7FFFFFFF) || (rsp_r2c1 == 32'h80000000) ||
      (rsp_r2c2 == 32'h7FFFFFFF) || (rsp_r2c2 == 32'h80000000);

   `M3INV_AST_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `M3INV_AST_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_r1c1) && $stable(rsp_saturated))
   `M3INV_AST_NOW(a_sat_clip, rsp_valid && rsp_saturated, any_clip)
   `M3INV_AST_NOW(a_reset_empty, $past(reset), !rsp_valid && req_ready)

endmodule

bind matrix3x3_inverse_top m3inv_checker u_m3inv_checker (.*);

FILE: tb/tb_matrix3x3_inverse_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for matrix3x3_inverse_top: streams 3x3 Q16.16 matrices,
// predicts each inverse (adjugate over determinant) and compares every response.
// Depends only on the RTL of the block.
module tb_matrix3x3_inverse_top;

   typedef logic [31:0] mat_type [9];

   typedef struct {
      logic [31:0] elem [9];
      logic        singular;
      logic        saturated;
   } inverse_type;

   // Inverse predictor and store of pending inverses
   class inverse_scoreboard;
      inverse_type pending_inv [$];
      int          errors;
      int          n_singular;
      int          n_saturated;
      int          n_checked;

      // element (r,c) of m as a 128-bit signed value
      function automatic logic signed [127:0] ext(mat_type m, int r, int c);
         logic signed [31:0] v;
         v = m[r*3+c];
         return 128'(v);
      endfunction

      // exact minor with row r and column c removed, Q32.32
      function automatic logic signed [127:0] minor_at(mat_type m, int r, int c);
         int ra, rb, ca, cb;
         ra = (r == 0) ? 1 : 0;
         rb = (r == 2) ? 1 : 2;
         ca = (c == 0) ? 1 : 0;
         cb = (c == 2) ? 1 : 2;
         return ext(m, ra, ca) * ext(m, rb, cb) - ext(m, ra, cb) * ext(m, rb, ca);
      endfunction

      // note an accepted request: compute its inverse and queue it
      function void note_request(mat_type m);
         logic signed [127:0] det, cof;
         logic [127:0] dmag, cmag, quo;
         logic neg;
         inverse_type inv;
         det = ext(m, 0, 0) * minor_at(m, 0, 0) - ext(m, 0, 1) * minor_at(m, 0, 1)
             + ext(m, 0, 2) * minor_at(m, 0, 2);
         inv.singular  = (det == 0);
         inv.saturated = 1'b0;
         if (inv.singular) det = 128'sd66 <<< 32;
         dmag = det[127] ? -det : det;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               cof = minor_at(m, c, r);
               if ((r + c) % 2 == 1) cof = -cof;
               neg  = cof[127] != det[127];
               cmag = cof[127] ? -cof : cof;
               quo  = (cmag << 32) / dmag;
               if (neg) begin
                  if (quo > 128'h80000000) begin
                     inv.elem[r*3+c] = 32'h80000000;
                     inv.saturated   = 1'b1;
                  end else begin
                     inv.elem[r*3+c] = -quo[31:0];
                  end
               end else begin
                  if (quo > 128'h7FFFFFFF) begin
                     inv.elem[r*3+c] = 32'h7FFFFFFF;
                     inv.saturated   = 1'b1;
                  end else begin
                     inv.elem[r*3+c] = quo[31:0];
                  end
               end
            end
         end
         if (inv.singular) n_singular++;
         if (inv.saturated) n_saturated++;
         pending_inv.push_back(inv);
      endfunction

      // check a response against the oldest pending inverse
      function void check_response(inverse_type got);
         inverse_type exp_inv;
         if (pending_inv.size() == 0) begin
            $display("%0t: response with no request pending", $time);
            errors++;
            return;
         end
         exp_inv = pending_inv.pop_front();
         n_checked++;
         for (int i = 0; i < 9; i++)
            if (got.elem[i] !== exp_inv.elem[i]) begin
               $display("%0t: r%0dc%0d expected %h actual %h", $time, i / 3, i % 3,
                        exp_inv.elem[i], got.elem[i]);
               errors++;
            end
         if (got.singular !== exp_inv.singular) begin
            $display("%0t: singular expected %b actual %b", $time,
                     exp_inv.singular, got.singular);
            errors++;
         end
         if (got.saturated !== exp_inv.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time,
                     exp_inv.saturated, got.saturated);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_e [9];
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_e [9];
   logic        rsp_singular, rsp_saturated;

   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   inverse_scoreboard inv_sb = new();

   initial for (int i = 0; i < 9; i++) req_e[i] = '0;

   matrix3x3_inverse_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_r0c0(req_e[0]), .req_r0c1(req_e[1]), .req_r0c2(req_e[2]),
      .req_r1c0(req_e[3]), .req_r1c1(req_e[4]), .req_r1c2(req_e[5]),
      .req_r2c0(req_e[6]), .req_r2c1(req_e[7]), .req_r2c2(req_e[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_r0c0(rsp_e[0]), .rsp_r0c1(rsp_e[1]), .rsp_r0c2(rsp_e[2]),
      .rsp_r1c0(rsp_e[3]), .rsp_r1c1(rsp_e[4]), .rsp_r1c2(rsp_e[5]),
      .rsp_r2c0(rsp_e[6]), .rsp_r2c1(rsp_e[7]), .rsp_r2c2(rsp_e[8]),
      .rsp_singular(rsp_singular), .rsp_saturated(rsp_saturated)
   );

   always #5 clock = ~clock;

   // stall the response side at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // record accepted requests and check accepted responses
   always @(posedge clock) begin
      inverse_type got;
      mat_type     m;
      if (!reset && req_valid && req_ready) begin
         for (int i = 0; i < 9; i++) m[i] = req_e[i];
         inv_sb.note_request(m);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         for (int i = 0; i < 9; i++) got.elem[i] = rsp_e[i];
         got.singular  = rsp_singular;
         got.saturated = rsp_saturated;
         inv_sb.check_response(got);
      end
   end

   // present one matrix, holding it until accepted
   task automatic send_matrix(mat_type m);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      for (int i = 0; i < 9; i++) req_e[i] <= m[i];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // build a matrix of one kind of random content
   task automatic random_matrix(output mat_type m);
      int kind;
      kind = $urandom_range(9);
      for (int i = 0; i < 9; i++) begin
         case (kind)
            0, 1: m[i] = $urandom();
            2, 3: m[i] = 32'($signed($urandom_range(4 * 65536)) - 2 * 65536);
            4:    m[i] = 32'($signed($urandom_range(512)) - 256);
            default: begin
               m[i] = 32'($signed($urandom_range(65536)) - 32768);
               if (i % 4 == 0) m[i] = m[i] + 32'(($urandom_range(1) ? 1 : -1) * 4 * 65536);
            end
         endcase
      end
      // make some of them singular: copy one row over another
      if ($urandom_range(9) == 0) begin
         for (int c = 0; c < 3; c++) m[6 + c] = m[c];
      end
   endtask

   task automatic send_diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      mat_type m;
      for (int i = 0; i < 9; i++) m[i] = '0;
      m[0] = a;
      m[4] = b;
      m[8] = c;
      send_matrix(m);
   endtask

   task automatic send_fill(logic [31:0] v);
      mat_type m;
      for (int i = 0; i < 9; i++) m[i] = v;
      send_matrix(m);
   endtask

   task automatic wait_drained();
      while (inv_sb.pending_inv.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   initial begin
      mat_type m;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, zero, extremes, tiny and signed diagonals
      snd_idle_pct = 6;
      rcv_idle_pct = 54;
      send_diag(32'h00010000, 32'h00010000, 32'h00010000);
      send_fill(32'h0);
      send_fill(32'h7FFFFFFF);
      send_fill(32'h80000000);
      send_fill(32'hFFFFFFFF);
      send_diag(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_diag(32'h80000000, 32'h80000000, 32'h80000000);
      send_diag(32'h80000000, 32'h7FFFFFFF, 32'h00000001);
      send_diag(32'h00000001, 32'h00000001, 32'h00000001);
      send_diag(32'hFFFF0000, 32'h00020000, 32'h00008000);
      send_diag(32'h00010000, 32'h00010000, 32'h00000000);
      send_diag(32'h00000100, 32'h00010000, 32'h00010000);
      m = '{32'h00010000, 32'h00020000, 32'h00030000, 32'h00040000, 32'h00050000,
            32'h00060000, 32'h00070000, 32'h00080000, 32'h000A0000};
      send_matrix(m);
      m = '{32'h00010000, 32'h00020000, 32'h00030000, 32'h00040000, 32'h00050000,
            32'h00060000, 32'h00070000, 32'h00080000, 32'h00090000};
      send_matrix(m);
      m = '{32'h0, 32'h00010000, 32'h0, 32'h00010000, 32'h0, 32'h0,
            32'h0, 32'h0, 32'hFFFF0000};
      send_matrix(m);
      m = '{32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F, 32'hF0F0F0F0, 32'h33333333,
            32'hCCCCCCCC, 32'h12345678, 32'h87654321, 32'hDEADBEEF};
      send_matrix(m);

      // random: three idle profiles
      for (int phase = 0; phase < 3; phase++) begin
         snd_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 54 : 0;
         rcv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 6 : 0;
         for (int n = 0; n < 400; n++) begin
            random_matrix(m);
            send_matrix(m);
         end
      end
      req_valid <= 1'b0;
      wait_drained();

      $display("Checked %0d inverses (%0d singular, %0d saturated) over three stall profiles.",
               inv_sb.n_checked, inv_sb.n_singular, inv_sb.n_saturated);
      if (inv_sb.errors == 0 && inv_sb.pending_inv.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // stop a hung run
   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: matrix3x3_inverse_top.f
+incdir+hdl
hdl/m3inv_pkg.sv
hdl/m3inv_front.sv
hdl/m3inv_queue.sv
hdl/m3inv_back.sv
hdl/matrix3x3_inverse_top.sv
hdl/m3inv_checker.sv
tb/tb_matrix3x3_inverse_top.sv
